### src/ctsc_pkg.sv
// ---------------------------------------------------------------------------
// ctsc_pkg
// Shared types, register indexes and helpers for the clock/timer/stopwatch
// controller.
// ---------------------------------------------------------------------------
package ctsc_pkg;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_MS   = 2'd0,
    REG_ALARM_MS      = 2'd1,
    REG_DIM_THRESHOLD = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_CLOCK     = 2'd0,
    MODE_TIMER     = 2'd1,
    MODE_STOPWATCH = 2'd2
  } mode_code_t;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_TICK   = 1'b1;

  localparam logic [15:0] DEBOUNCE_MS_RESET   = 16'd50;
  localparam logic [15:0] ALARM_MS_RESET      = 16'd10000;
  localparam logic [9:0]  DIM_THRESHOLD_RESET = 10'd800;

  localparam int BTN_MODE   = 0;
  localparam int BTN_HOUR   = 1;
  localparam int BTN_MINUTE = 2;
  localparam int BTN_START  = 3;

  typedef struct packed {
    logic       action;
    logic [3:0] buttons;
    logic [9:0] slider;
    logic [9:0] light;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       editing_hour;
    logic       editing_minute;
    logic       running;
    logic       alarm_on;
    logic       chirp;
    logic       dim;
  } out_item_t;

  // floor(p / 1023) for p < 1023*64: p = q*1024 + r gives p = q*1023 + (r + q)
  function automatic logic [5:0] div1023(input logic [15:0] p);
    logic [5:0]  q;
    logic [10:0] rem;
    q   = p[15:10];
    rem = {1'b0, p[9:0]} + {5'd0, q};
    if (rem >= 11'd1023) begin
      q = q + 6'd1;
    end
    return q;
  endfunction

  // v*span/1023 + base, clamped to top
  function automatic logic [5:0] slide_map(input logic [9:0] v, input logic [5:0] span,
                                           input logic [5:0] base, input logic [5:0] top);
    logic [15:0] prod;
    logic [6:0]  r;
    prod = 16'(v * span);
    r    = {1'b0, div1023(prod)} + {1'b0, base};
    if (r > {1'b0, top}) begin
      r = {1'b0, top};
    end
    return r[5:0];
  endfunction

endpackage

### src/ctsc_debounce.sv
// ---------------------------------------------------------------------------
// ctsc_debounce
// Four-lane button debouncer; flags accepted presses (falling stable level).
// ---------------------------------------------------------------------------
module ctsc_debounce #(
  parameter int DEBOUNCE_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [3:0]  buttons,
  input  logic [15:0] debounce_ms,
  output logic [3:0]  press
);

  localparam logic [DEBOUNCE_COUNT_WIDTH-1:0] CountMax = '1;

  logic [3:0] stable_level, stable_level_next;
  logic [3:0] last_raw;
  logic [DEBOUNCE_COUNT_WIDTH-1:0] steady_count [4];
  logic [DEBOUNCE_COUNT_WIDTH-1:0] steady_count_next [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (buttons[i] != last_raw[i]) begin
        steady_count_next[i] = '0;
      end else if (steady_count[i] < CountMax) begin
        steady_count_next[i] = steady_count[i] + 1'b1;
      end else begin
        steady_count_next[i] = steady_count[i];
      end
      stable_level_next[i] = stable_level[i];
      press[i] = 1'b0;
      if (64'(steady_count_next[i]) > 64'(debounce_ms) &&
          buttons[i] != stable_level[i]) begin
        stable_level_next[i] = buttons[i];
        press[i] = en && !buttons[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= '1;
      last_raw     <= '1;
      for (int i = 0; i < 4; i++) begin
        steady_count[i] <= '0;
      end
    end else if (en) begin
      stable_level <= stable_level_next;
      last_raw     <= buttons;
      for (int i = 0; i < 4; i++) begin
        steady_count[i] <= steady_count_next[i];
      end
    end
  end

endmodule

### src/ctsc_core.sv
// ---------------------------------------------------------------------------
// ctsc_core
// Mode/edit control, counters, countdown expiry and alarm; forms the result.
// ---------------------------------------------------------------------------
module ctsc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ctsc_pkg::in_item_t  item,
  input  logic [3:0]          press,
  input  logic [15:0]         alarm_ms,
  input  logic [9:0]          dim_threshold,
  output ctsc_pkg::out_item_t result
);

  logic [1:0]  mode_reg, mode_reg_next;
  logic        edit_hour, edit_hour_next;
  logic        edit_minute, edit_minute_next;
  logic        clock_frozen, clock_frozen_next;
  logic        timer_running, timer_running_next;
  logic        stopwatch_running, stopwatch_running_next;
  logic        alarm_active, alarm_active_next;
  logic [15:0] alarm_elapsed, alarm_elapsed_next;
  logic [4:0]  clk_h, clk_h_next;
  logic [5:0]  clk_m, clk_m_next, clk_s, clk_s_next;
  logic [4:0]  tmr_h, tmr_h_next;
  logic [5:0]  tmr_m, tmr_m_next, tmr_s, tmr_s_next;
  logic [6:0]  sw_h, sw_h_next;
  logic [5:0]  sw_m, sw_m_next, sw_s, sw_s_next;

  logic sample;
  logic editing;
  logic tmr_zero;
  logic [5:0] hour_map;

  assign sample = (item.action == ctsc_pkg::ACTION_SAMPLE);

  always_comb begin
    mode_reg_next          = mode_reg;
    edit_hour_next         = edit_hour;
    edit_minute_next       = edit_minute;
    clock_frozen_next      = clock_frozen;
    timer_running_next     = timer_running;
    stopwatch_running_next = stopwatch_running;
    alarm_active_next      = alarm_active;
    alarm_elapsed_next     = alarm_elapsed;
    clk_h_next = clk_h; clk_m_next = clk_m; clk_s_next = clk_s;
    tmr_h_next = tmr_h; tmr_m_next = tmr_m; tmr_s_next = tmr_s;
    sw_h_next  = sw_h;  sw_m_next  = sw_m;  sw_s_next  = sw_s;
    editing  = edit_hour || edit_minute;
    hour_map = ctsc_pkg::slide_map(item.slider, 6'd24, 6'd0, 6'd23);

    if (sample) begin
      // presses in fixed order: mode, hour edit, minute edit, start/stop
      if (press[ctsc_pkg::BTN_MODE] && !(edit_hour_next || edit_minute_next)) begin
        mode_reg_next = (mode_reg_next >= ctsc_pkg::MODE_STOPWATCH) ?
                        ctsc_pkg::MODE_CLOCK : mode_reg_next + 2'd1;
      end
      if (press[ctsc_pkg::BTN_HOUR]) begin
        edit_hour_next = !edit_hour_next;
        if (edit_hour_next) edit_minute_next = 1'b0;
        if (mode_reg_next == ctsc_pkg::MODE_CLOCK) clock_frozen_next = edit_hour_next;
      end
      if (press[ctsc_pkg::BTN_MINUTE]) begin
        edit_minute_next = !edit_minute_next;
        if (edit_minute_next) edit_hour_next = 1'b0;
        if (mode_reg_next == ctsc_pkg::MODE_CLOCK) clock_frozen_next = edit_minute_next;
      end
      if (press[ctsc_pkg::BTN_START]) begin
        if (mode_reg_next == ctsc_pkg::MODE_TIMER) begin
          if (alarm_active_next) begin
            alarm_active_next  = 1'b0;
            timer_running_next = 1'b0;
            tmr_h_next = 5'd0; tmr_m_next = 6'd1; tmr_s_next = 6'd0;
          end else begin
            timer_running_next = !timer_running_next;
          end
        end else if (mode_reg_next == ctsc_pkg::MODE_STOPWATCH) begin
          stopwatch_running_next = !stopwatch_running_next;
        end
      end

      // slider edit
      if (edit_minute_next) begin
        case (mode_reg_next)
          ctsc_pkg::MODE_CLOCK:
            clk_m_next = ctsc_pkg::slide_map(item.slider, 6'd60, 6'd0, 6'd59);
          ctsc_pkg::MODE_TIMER:
            tmr_m_next = ctsc_pkg::slide_map(item.slider, 6'd59, 6'd1, 6'd59);
          ctsc_pkg::MODE_STOPWATCH:
            sw_m_next = ctsc_pkg::slide_map(item.slider, 6'd60, 6'd0, 6'd59);
          default: ;
        endcase
      end else if (edit_hour_next) begin
        case (mode_reg_next)
          ctsc_pkg::MODE_CLOCK:     clk_h_next = hour_map[4:0];
          ctsc_pkg::MODE_TIMER:     tmr_h_next = hour_map[4:0];
          ctsc_pkg::MODE_STOPWATCH: sw_h_next  = {1'b0, hour_map};
          default: ;
        endcase
      end

      if (alarm_active_next && alarm_elapsed_next != 16'hFFFF) begin
        alarm_elapsed_next = alarm_elapsed_next + 16'd1;
      end
    end else begin
      if (!clock_frozen) begin
        clk_s_next = clk_s + 6'd1;
        if (clk_s_next >= 6'd60) begin
          clk_s_next = 6'd0;
          clk_m_next = clk_m + 6'd1;
        end
        if (clk_m_next >= 6'd60) begin
          clk_m_next = 6'd0;
          clk_h_next = clk_h + 5'd1;
        end
        if (clk_h_next >= 5'd24) clk_h_next = 5'd0;
      end
      if (!editing && timer_running && !alarm_active &&
          (tmr_h != 5'd0 || tmr_m != 6'd0 || tmr_s != 6'd0)) begin
        if (tmr_s != 6'd0) begin
          tmr_s_next = tmr_s - 6'd1;
        end else begin
          tmr_s_next = 6'd59;
          if (tmr_m != 6'd0) begin
            tmr_m_next = tmr_m - 6'd1;
          end else begin
            tmr_m_next = 6'd59;
            tmr_h_next = tmr_h - 5'd1;
          end
        end
      end
      if (!editing && stopwatch_running) begin
        sw_s_next = sw_s + 6'd1;
        if (sw_s_next >= 6'd60) begin
          sw_s_next = 6'd0;
          sw_m_next = sw_m + 6'd1;
        end
        if (sw_m_next >= 6'd60) begin
          sw_m_next = 6'd0;
          sw_h_next = sw_h + 7'd1;
        end
        if (sw_h_next > 7'd99) sw_h_next = 7'd0;
      end
    end

    // expiry / alarm timeout, on samples and ticks alike
    tmr_zero = (tmr_h_next == 5'd0) && (tmr_m_next == 6'd0) && (tmr_s_next == 6'd0);
    if (tmr_zero) begin
      if (alarm_active_next) begin
        if (alarm_elapsed_next >= alarm_ms) begin
          alarm_active_next  = 1'b0;
          timer_running_next = 1'b0;
          tmr_h_next = 5'd0; tmr_m_next = 6'd1; tmr_s_next = 6'd0;
        end
      end else begin
        alarm_active_next  = 1'b1;
        timer_running_next = 1'b0;
        alarm_elapsed_next = 16'd0;
      end
    end

    result.mode           = mode_reg_next;
    result.editing_hour   = edit_hour_next;
    result.editing_minute = edit_minute_next;
    result.alarm_on       = alarm_active_next;
    result.chirp          = sample && (press != 4'd0);
    result.dim            = item.light > dim_threshold;
    case (mode_reg_next)
      ctsc_pkg::MODE_TIMER: begin
        result.hours   = {2'd0, tmr_h_next};
        result.minutes = tmr_m_next;
        result.seconds = tmr_s_next;
        result.running = timer_running_next;
      end
      ctsc_pkg::MODE_STOPWATCH: begin
        result.hours   = sw_h_next;
        result.minutes = sw_m_next;
        result.seconds = sw_s_next;
        result.running = stopwatch_running_next;
      end
      default: begin
        result.hours   = {2'd0, clk_h_next};
        result.minutes = clk_m_next;
        result.seconds = clk_s_next;
        result.running = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= ctsc_pkg::MODE_CLOCK;
      edit_hour         <= 1'b0;
      edit_minute       <= 1'b0;
      clock_frozen      <= 1'b0;
      timer_running     <= 1'b0;
      stopwatch_running <= 1'b0;
      alarm_active      <= 1'b0;
      alarm_elapsed     <= 16'd0;
      clk_h <= 5'd0; clk_m <= 6'd0; clk_s <= 6'd0;
      tmr_h <= 5'd0; tmr_m <= 6'd0; tmr_s <= 6'd3;
      sw_h  <= 7'd0; sw_m  <= 6'd0; sw_s  <= 6'd0;
    end else if (en) begin
      mode_reg          <= mode_reg_next;
      edit_hour         <= edit_hour_next;
      edit_minute       <= edit_minute_next;
      clock_frozen      <= clock_frozen_next;
      timer_running     <= timer_running_next;
      stopwatch_running <= stopwatch_running_next;
      alarm_active      <= alarm_active_next;
      alarm_elapsed     <= alarm_elapsed_next;
      clk_h <= clk_h_next; clk_m <= clk_m_next; clk_s <= clk_s_next;
      tmr_h <= tmr_h_next; tmr_m <= tmr_m_next; tmr_s <= tmr_s_next;
      sw_h  <= sw_h_next;  sw_m  <= sw_m_next;  sw_s  <= sw_s_next;
    end
  end

endmodule

### src/clock_timer_stopwatch_controller.sv
// ---------------------------------------------------------------------------
// clock_timer_stopwatch_controller
// Clock, countdown timer and stopwatch with debounced buttons and slider edit.
// ---------------------------------------------------------------------------
// Every beat (millisecond sample or one-second tick) gives one result beat.
// A beat is captured in an input register, handled by combinational logic
// (debounce, presses, edit, counters, expiry) and lands in the output
// register; one beat per cycle is sustained while out_ready holds. The input
// side keeps taking beats while a result waits, stalling only when both
// registers are full. Configuration writes are always taken.
module clock_timer_stopwatch_controller #(
  parameter int DEBOUNCE_COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ctsc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [15:0] debounce_ms;
  logic [15:0] alarm_ms;
  logic [9:0]  dim_threshold;

  logic                s1_valid;
  ctsc_pkg::in_item_t  s1_item;
  logic                advance;
  logic                go;
  logic [3:0]          press;
  ctsc_pkg::out_item_t result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign go        = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= ctsc_pkg::DEBOUNCE_MS_RESET;
      alarm_ms      <= ctsc_pkg::ALARM_MS_RESET;
      dim_threshold <= ctsc_pkg::DIM_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ctsc_pkg::REG_DEBOUNCE_MS:   debounce_ms   <= cfg_data;
        ctsc_pkg::REG_ALARM_MS:      alarm_ms      <= cfg_data;
        ctsc_pkg::REG_DIM_THRESHOLD: dim_threshold <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= result;
    end
  end

  ctsc_debounce #(
    .DEBOUNCE_COUNT_WIDTH(DEBOUNCE_COUNT_WIDTH)
  ) u_debounce (
    .clk        (clk),
    .rst        (rst),
    .en         (go && (s1_item.action == ctsc_pkg::ACTION_SAMPLE)),
    .buttons    (s1_item.buttons),
    .debounce_ms(debounce_ms),
    .press      (press)
  );

  ctsc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .en           (go),
    .item         (s1_item),
    .press        (press),
    .alarm_ms     (alarm_ms),
    .dim_threshold(dim_threshold),
    .result       (result)
  );

endmodule
